>>> rtl/cce_pkg.sv
// Shared constants and types for the CNF clause evaluator.
`default_nettype none
package cce_pkg;

  localparam int MAX_VARS   = 1024;
  localparam int AddrW      = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int VarIdxW    = 11;
  localparam int LenW       = 11;
  localparam int ValW       = 2;
  localparam int StatW      = 2;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncLit   = 1'b1;

  localparam logic [ValW-1:0] ValFalse = 2'd0;
  localparam logic [ValW-1:0] ValTrue  = 2'd1;
  localparam logic [ValW-1:0] ValOpen  = 2'd2;

  localparam logic [StatW-1:0] StatSat   = 2'd0;
  localparam logic [StatW-1:0] StatUnsat = 2'd1;
  localparam logic [StatW-1:0] StatUndet = 2'd2;

  // One literal as handed from the front to the back.
  typedef struct packed {
    logic            counted;
    logic            negated;
    logic            clause_last;
    logic            formula_last;
    logic [ValW-1:0] value;
  } lit_t;

endpackage
`default_nettype wire

>>> rtl/cce_if.sv
// Valid/ready channel interfaces for input items and clause results.
`default_nettype none
interface cce_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [cce_pkg::VarIdxW-1:0] var_index;
  logic [cce_pkg::ValW-1:0]    var_value;
  logic                        lit_negated;
  logic                        clause_last;
  logic                        formula_last;

  modport source (output valid, func, var_index, var_value, lit_negated, clause_last,
                  formula_last, input ready);
  modport sink   (input valid, func, var_index, var_value, lit_negated, clause_last,
                  formula_last, output ready);
endinterface

interface cce_out_if;
  logic                      valid;
  logic                      ready;
  logic [cce_pkg::StatW-1:0] clause_status;
  logic                      formula_done;
  logic                      formula_satisfied;

  modport source (output valid, clause_status, formula_done, formula_satisfied,
                  input ready);
  modport sink   (input valid, clause_status, formula_done, formula_satisfied,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/cce_front.sv
// Front end: accepts words, owns the assignment store, classifies literals.
`default_nettype none
module cce_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  cce_in_if.sink                     item,
  input  wire logic [cce_pkg::LenW-1:0] assign_len,
  output logic                       push,
  output cce_pkg::lit_t              push_word,
  input  wire logic                  q_full
);
  import cce_pkg::*;

  logic [ValW-1:0]  mem [MAX_VARS];
  logic [ValW-1:0]  rdata;
  logic             clearing;
  logic [AddrW-1:0] clr_addr;

  logic             stage_valid;
  logic             stage_counted;
  logic             stage_neg;
  logic             stage_clast;
  logic             stage_flast;

  logic                accept;
  logic                lit_acc;
  logic [VarIdxW-1:0]  idx_m1;
  logic [AddrW-1:0]    addr;
  logic                in_store;
  logic                counted;
  logic                wr_en;
  logic [AddrW-1:0]    wr_addr;
  logic [ValW-1:0]     wr_data;
  logic                rd_en;

  assign item.ready = !clearing && (!stage_valid || !q_full);
  assign accept     = item.valid && item.ready;
  assign lit_acc    = accept && (item.func == FuncLit);

  assign idx_m1   = item.var_index - VarIdxW'(1);
  assign addr     = AddrW'(idx_m1);
  assign in_store = (item.var_index != '0) && (32'(item.var_index) <= MAX_VARS);
  assign counted  = in_store && (item.var_index <= assign_len);

  assign wr_en   = clearing || (accept && (item.func == FuncWrite) && in_store);
  assign wr_addr = clearing ? clr_addr : addr;
  assign wr_data = clearing ? ValOpen : item.var_value;
  assign rd_en   = lit_acc && counted;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

  // clearing pass over the whole store after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AddrW'(1);
      if (clr_addr == AddrW'(MAX_VARS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= lit_acc || (stage_valid && q_full);
    end
  end

  always_ff @(posedge clk) begin
    if (lit_acc) begin
      stage_counted <= counted;
      stage_neg     <= item.lit_negated;
      stage_clast   <= item.clause_last;
      stage_flast   <= item.formula_last;
    end
  end

  assign push = stage_valid && !q_full;

  always_comb begin
    push_word.counted      = stage_counted;
    push_word.negated      = stage_neg;
    push_word.clause_last  = stage_clast;
    push_word.formula_last = stage_flast;
    push_word.value        = rdata;
  end

endmodule
`default_nettype wire

>>> rtl/cce_queue.sv
// Short FIFO of classified literals between front and back.
`default_nettype none
module cce_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire cce_pkg::lit_t push_word,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output cce_pkg::lit_t      head_word
);
  import cce_pkg::*;

  lit_t             store [QueueDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == QCntW'(QueueDepth));
  assign head_valid = (count != '0);
  assign head_word  = store[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/cce_back.sv
// Back end: clause and formula accumulators and the result register.
`default_nettype none
module cce_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  wire cce_pkg::lit_t head_word,
  output logic               pop,
  cce_out_if.source          result
);
  import cce_pkg::*;

  logic             has_true;
  logic             has_open;
  logic             all_true;
  logic             out_valid;
  logic [StatW-1:0] out_status;
  logic             out_done;
  logic             out_sat;

  logic             lit_true;
  logic             lit_open;
  logic             has_true_next;
  logic             has_open_next;
  logic             all_true_next;
  logic             ends;
  logic [StatW-1:0] status;

  assign pop = head_valid && (!out_valid || result.ready);

  assign lit_true = head_word.counted &&
                    (((head_word.value == ValFalse) && head_word.negated) ||
                     ((head_word.value == ValTrue) && !head_word.negated));
  // stored codes other than false and true read as unassigned
  assign lit_open = head_word.counted && (head_word.value != ValFalse) &&
                    (head_word.value != ValTrue);

  assign has_true_next = has_true || lit_true;
  assign has_open_next = has_open || lit_open;
  assign all_true_next = all_true && has_true_next;
  assign ends          = head_word.clause_last || head_word.formula_last;

  always_comb begin
    priority if (has_true_next) begin
      status = StatSat;
    end else if (has_open_next) begin
      status = StatUndet;
    end else begin
      status = StatUnsat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      has_true  <= 1'b0;
      has_open  <= 1'b0;
      all_true  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (ends) begin
          has_true <= 1'b0;
          has_open <= 1'b0;
          all_true <= head_word.formula_last ? 1'b1 : all_true_next;
        end else begin
          has_true <= has_true_next;
          has_open <= has_open_next;
        end
      end
      if (pop && ends) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && ends) begin
      out_status <= status;
      out_done   <= head_word.formula_last;
      out_sat    <= head_word.formula_last && all_true_next;
    end
  end

  assign result.valid             = out_valid;
  assign result.clause_status     = out_status;
  assign result.formula_done      = out_done;
  assign result.formula_satisfied = out_sat;

endmodule
`default_nettype wire

>>> rtl/cnf_clause_evaluator.sv
// Top level of the CNF clause evaluator: front, literal queue, back.
//
//  channel  | dir | handshake     | word
//  ---------+-----+---------------+-------------------------------------------
//  item     | in  | valid/ready   | func, var_index, var_value, lit_negated,
//           |     |               | clause_last, formula_last
//  result   | out | valid/ready   | clause_status, formula_done,
//           |     |               | formula_satisfied
//  cfg      | in  | cfg_we        | cfg_wdata = assignment_length
//
// One word per cycle sustained. A literal's verdict reaches the result
// register through the store read at the accepting edge, the queue push and
// the accumulator; a write lands in the store at its accepting edge.
// After reset the store is swept to unassigned, one entry a cycle, with
// item.ready low; cfg writes are taken meanwhile. A stalled result holds the
// back; the four-deep queue lets the front keep taking words until it fills,
// then item.ready drops.
`default_nettype none
module cnf_clause_evaluator (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [cce_pkg::LenW-1:0] cfg_wdata,
  cce_in_if.sink                        item,
  cce_out_if.source                     result
);
  import cce_pkg::*;

  logic [LenW-1:0] assign_len;

  // literal path between the halves
  logic push;
  lit_t push_word;
  logic q_full;
  logic pop;
  logic head_valid;
  lit_t head_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      assign_len <= '0;
    end else if (cfg_we) begin
      assign_len <= cfg_wdata;
    end
  end

  // store access and classification of each literal
  cce_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .assign_len (assign_len),
    .push       (push),
    .push_word  (push_word),
    .q_full     (q_full)
  );

  // decouples store reads from result back-pressure
  cce_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_word  (push_word),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_word  (head_word)
  );

  // per-clause flags, per-formula flag, result register
  cce_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_word  (head_word),
    .pop        (pop),
    .result     (result)
  );

endmodule
`default_nettype wire
